/* src/plid_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plid_pkg: shared types and codes for the positional insert/delete list
// Holds the request codes, status codes, word width and the command that the
// top level broadcasts to every entry cell.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int POS_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int DEPTH_DEF = 64;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_APPEND    = 3'd1,
    OP_READ      = 3'd2,
    OP_INSERT    = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_DELETE    = 3'd5
  } kind_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // per-cycle cell command
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_WRITE  = 2'd1,
    CM_INSERT = 2'd2,
    CM_DELETE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [DATA_W-1:0] word;
  } ctl_t;

endpackage

`default_nettype wire

/* src/plid_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plid_cell: one entry of the list
// Holds one word; on a command it loads the new word, takes its lower
// neighbor (insert shift) or its upper neighbor (delete shift), else holds.
// ----------------------------------------------------------------------------
module plid_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  wire                        clk,
  input  plid_pkg::ctl_t             ctl,
  input  wire [IW-1:0]               target,
  input  wire [plid_pkg::DATA_W-1:0] lower_word,
  input  wire [plid_pkg::DATA_W-1:0] upper_word,
  output logic [plid_pkg::DATA_W-1:0] word,
  output logic [plid_pkg::DATA_W-1:0] hit_word
);
  import plid_pkg::*;

  logic hit;
  logic above;

  assign hit      = (target == IW'(IDX));
  assign above    = (IW'(IDX) > target);
  assign hit_word = hit ? word : '0;

  // entry update, no reset: contents are undefined until written
  always_ff @(posedge clk) begin
    case (ctl.mode)
      CM_WRITE: begin
        if (hit) word <= ctl.word;
      end
      CM_INSERT: begin
        if (hit) word <= ctl.word;
        else if (above) word <= lower_word;
      end
      CM_DELETE: begin
        if (hit || above) word <= upper_word;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/positional_insert_delete_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_insert_delete_list: ordered list of 32-bit words
// Clear, append, read, insert, overwrite and delete at a 1-based position.
// ----------------------------------------------------------------------------
// No request walks the list one entry at a time: the entries sit in a row of DEPTH
// cells that all shift toward or away from the target position at once, so
// a request is taken in each cycle while the result register is free or
// being drained, and its result appears in the next cycle. A read ORs the
// masked outputs of all cells. Bad positions give status 1, a full list
// status 2, and either leaves the list untouched. entry_count is the live
// count truncated to 7 bits.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
  parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [plid_pkg::KIND_W-1:0]   kind,
  input  wire [plid_pkg::POS_W-1:0]    position,
  input  wire signed [plid_pkg::DATA_W-1:0] value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [plid_pkg::STATUS_W-1:0] status,
  output logic [plid_pkg::COUNT_W-1:0] entry_count,
  output logic signed [plid_pkg::DATA_W-1:0] read_word
);
  import plid_pkg::*;

  localparam int IW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CW-1:0]     posx;
  logic [CW-1:0]     cntx;
  logic [CW-1:0]     cntx_next;
  logic [CW-1:0]     pos_m1;
  logic              in_list;
  logic              ins_ok;
  logic              full;
  logic              accept;
  logic [IW-1:0]     target;
  mode_t             mode;
  status_t           st;
  logic [DATA_W-1:0] word_next;
  logic [DATA_W-1:0] rd_or;
  ctl_t              ctl;

  logic [DATA_W-1:0] cell_word [DEPTH];
  logic [DATA_W-1:0] cell_hit  [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // position checks against the live count
  assign posx    = CW'(position);
  assign cntx    = CW'(cnt);
  assign pos_m1  = posx - CW'(1);
  assign in_list = (posx != '0) && (posx <= cntx);
  assign ins_ok  = (posx != '0) && (posx <= cntx + CW'(1));
  assign full    = (cntx == CW'(DEPTH));

  // read selection: OR of the masked cell outputs
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_hit[i];
    end
  end

  // decode the request
  always_comb begin
    st        = ST_OK;
    mode      = CM_HOLD;
    target    = pos_m1[IW-1:0];
    cnt_next  = cnt;
    word_next = '0;
    case (kind)
      OP_CLEAR: begin
        cnt_next = '0;
      end
      OP_APPEND: begin
        target = cntx[IW-1:0];
        if (full) st = ST_FULL;
        else begin
          mode     = CM_WRITE;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!in_list) st = ST_BADPOS;
        else word_next = rd_or;
      end
      OP_INSERT: begin
        if (!ins_ok) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else begin
          mode     = CM_INSERT;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      OP_OVERWRITE: begin
        if (!in_list) st = ST_BADPOS;
        else mode = CM_WRITE;
      end
      OP_DELETE: begin
        if (!in_list) st = ST_BADPOS;
        else begin
          mode     = CM_DELETE;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign cntx_next = CW'(cnt_next);
  assign ctl.mode  = accept ? mode : CM_HOLD;
  assign ctl.word  = value;

  // row of entry cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = cell_word[g];
    end else begin : g_mid_hi
      assign upper = cell_word[g+1];
    end
    plid_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .target     (target),
      .lower_word (lower),
      .upper_word (upper),
      .word       (cell_word[g]),
      .hit_word   (cell_hit[g])
    );
  end

  // live count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= st;
      entry_count <= cntx_next[COUNT_W-1:0];
      read_word   <= word_next;
    end
  end

endmodule

`default_nettype wire
